### src/yuvrgb_pkg.sv
// Shared types, constants and helpers of the YUYV to scaled RGB converter.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package yuvrgb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FRAC_W = 16;
  // Signed width of one chroma product or the green pair of products.
  localparam int unsigned TERM_W = 26;
  // Signed width of luma in Q16 plus one chroma term.
  localparam int unsigned SUM_W  = 27;
  localparam int unsigned IN_W   = 4 * BYTE_W;
  localparam int unsigned OUT_W  = 6 * BYTE_W;

  // Q16 coefficients, rounded to nearest.
  localparam logic signed [TERM_W-1:0] COEF_KR  = TERM_W'(89831);
  localparam logic signed [TERM_W-1:0] COEF_KGV = TERM_W'(45744);
  localparam logic signed [TERM_W-1:0] COEF_KGU = TERM_W'(22127);
  localparam logic signed [TERM_W-1:0] COEF_KB  = TERM_W'(113538);

  localparam logic [BYTE_W-1:0] SCALE_MUL = BYTE_W'(220);
  localparam logic [BYTE_W-1:0] CHAN_MAX  = BYTE_W'(255);
  localparam logic [BYTE_W-1:0] SCALED_MAX = BYTE_W'(219);

  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] green;   // KGV*dV + KGU*dU, subtracted in the lane
    logic signed [TERM_W-1:0] blue;
  } chroma_terms_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // Truncate toward zero and clamp to 0..255; any negative sum lands on zero.
  function automatic logic [BYTE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic [BYTE_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum[SUM_W-2:FRAC_W+BYTE_W] != '0) begin
      res = CHAN_MAX;
    end else begin
      res = sum[FRAC_W+BYTE_W-1:FRAC_W];
    end
    return res;
  endfunction

  // floor(c * 220 / 256)
  function automatic logic [BYTE_W-1:0] scale_channel(input logic [BYTE_W-1:0] c);
    logic [2*BYTE_W-1:0] prod;
    prod = {{BYTE_W{1'b0}}, c} * {{BYTE_W{1'b0}}, SCALE_MUL};
    return prod[2*BYTE_W-1:BYTE_W];
  endfunction

endpackage

### src/yuyv_to_rgb_scaled_core.sv
// YUYV 4:2:2 word to two RGB888 pixels, clamped and scaled by 220/256.
// Throughput: one item per clock while out_tready does not stall the pipe.
// Three register stages (chroma terms, clamped lanes, scaled output) advance together;
// out_tready stalls the whole pipe, and in_tready follows it combinationally.
// Reset (rst_n low, synchronous) clears the stage valid flags only; data is not cleared.
// Depends on yuvrgb_pkg, yuvrgb_chroma, yuvrgb_lane and yuvrgb_merge.
`timescale 1ns / 1ps

module yuyv_to_rgb_scaled_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
  input  logic [yuvrgb_pkg::IN_W-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // red_first[7:0], green_first[15:8], blue_first[23:16],
  // red_second[31:24], green_second[39:32], blue_second[47:40]
  output logic [yuvrgb_pkg::OUT_W-1:0] out_tdata
);

  logic                      advance;
  logic                      chroma_vld_r, chroma_vld_nxt;
  logic                      lane_vld_r, lane_vld_nxt;
  logic                      out_vld_r, out_vld_nxt;
  yuvrgb_pkg::chroma_terms_t terms;
  logic [7:0]                luma_first_d;
  logic [7:0]                luma_second_d;
  yuvrgb_pkg::rgb_t          pixel_first;
  yuvrgb_pkg::rgb_t          pixel_second;

  // The pipe moves whenever the output register is empty or being drained.
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = advance;

  assign chroma_vld_nxt = advance ? in_tvalid    : chroma_vld_r;
  assign lane_vld_nxt   = advance ? chroma_vld_r : lane_vld_r;
  assign out_vld_nxt    = advance ? lane_vld_r   : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_vld_r <= 1'b0;
      lane_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      chroma_vld_r <= chroma_vld_nxt;
      lane_vld_r   <= lane_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Stage 1: chroma terms shared by both pixels.
  yuvrgb_chroma u_chroma (
    .clk           (clk),
    .load          (advance),
    .luma_first    (in_tdata[7:0]),
    .chroma_blue   (in_tdata[15:8]),
    .luma_second   (in_tdata[23:16]),
    .chroma_red    (in_tdata[31:24]),
    .terms_r       (terms),
    .luma_first_r  (luma_first_d),
    .luma_second_r (luma_second_d)
  );

  // Stage 2: one lane per pixel, side by side.
  yuvrgb_lane u_lane_first (
    .clk     (clk),
    .load    (advance),
    .luma    (luma_first_d),
    .terms   (terms),
    .pixel_r (pixel_first)
  );

  yuvrgb_lane u_lane_second (
    .clk     (clk),
    .load    (advance),
    .luma    (luma_second_d),
    .terms   (terms),
    .pixel_r (pixel_second)
  );

  // Stage 3: scale and pack into the output register; hold it while stalled.
  yuvrgb_merge u_merge (
    .clk          (clk),
    .load         (advance),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .tdata_r      (out_tdata)
  );

  assign out_tvalid = out_vld_r;

  // An accepted item occupies the chroma stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> chroma_vld_r)
    else $error("accepted item did not enter the chroma stage");

  // A valid lane result moves into the output register when the pipe advances.
  a_lane_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    lane_vld_r && advance |=> out_tvalid)
    else $error("lane result lost on the way to the output");

  // A stall freezes the inner stages.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(chroma_vld_r) && $stable(lane_vld_r))
    else $error("pipeline stage changed during a stall");

  // Scaled channels never exceed 219.
  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0]   <= yuvrgb_pkg::SCALED_MAX &&
                   out_tdata[15:8]  <= yuvrgb_pkg::SCALED_MAX &&
                   out_tdata[23:16] <= yuvrgb_pkg::SCALED_MAX &&
                   out_tdata[31:24] <= yuvrgb_pkg::SCALED_MAX &&
                   out_tdata[39:32] <= yuvrgb_pkg::SCALED_MAX &&
                   out_tdata[47:40] <= yuvrgb_pkg::SCALED_MAX)
    else $error("scaled channel out of range");

endmodule

### src/yuvrgb_chroma.sv
// Shared chroma stage: offset U and V and form the three coefficient terms.
// Depends on yuvrgb_pkg.
`timescale 1ns / 1ps

module yuvrgb_chroma (
  input  logic                      clk,
  input  logic                      load,
  input  logic [7:0]                luma_first,
  input  logic [7:0]                chroma_blue,
  input  logic [7:0]                luma_second,
  input  logic [7:0]                chroma_red,
  output yuvrgb_pkg::chroma_terms_t terms_r,
  output logic [7:0]                luma_first_r,
  output logic [7:0]                luma_second_r
);

  localparam int unsigned EXT_W = yuvrgb_pkg::TERM_W - 8;

  logic signed [yuvrgb_pkg::TERM_W-1:0] du;
  logic signed [yuvrgb_pkg::TERM_W-1:0] dv;
  yuvrgb_pkg::chroma_terms_t            terms_nxt;

  // Byte minus 128 is the byte with its top bit flipped, read as signed.
  assign du = $signed({{EXT_W{~chroma_blue[7]}}, ~chroma_blue[7], chroma_blue[6:0]});
  assign dv = $signed({{EXT_W{~chroma_red[7]}}, ~chroma_red[7], chroma_red[6:0]});

  always_comb begin
    terms_nxt.red   = yuvrgb_pkg::COEF_KR * dv;
    terms_nxt.green = yuvrgb_pkg::COEF_KGV * dv + yuvrgb_pkg::COEF_KGU * du;
    terms_nxt.blue  = yuvrgb_pkg::COEF_KB * du;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r       <= terms_nxt;
      luma_first_r  <= luma_first;
      luma_second_r <= luma_second;
    end
  end

endmodule

### src/yuvrgb_lane.sv
// One pixel lane: add luma to the chroma terms, truncate and clamp each channel.
// Depends on yuvrgb_pkg.
`timescale 1ns / 1ps

module yuvrgb_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic [7:0]                luma,
  input  yuvrgb_pkg::chroma_terms_t terms,
  output yuvrgb_pkg::rgb_t          pixel_r
);

  logic signed [yuvrgb_pkg::SUM_W-1:0] base;
  logic signed [yuvrgb_pkg::SUM_W-1:0] sum_red;
  logic signed [yuvrgb_pkg::SUM_W-1:0] sum_green;
  logic signed [yuvrgb_pkg::SUM_W-1:0] sum_blue;
  yuvrgb_pkg::rgb_t                    pixel_nxt;

  assign base = $signed({3'b000, luma, {yuvrgb_pkg::FRAC_W{1'b0}}});

  always_comb begin
    sum_red   = base + yuvrgb_pkg::SUM_W'(terms.red);
    sum_green = base - yuvrgb_pkg::SUM_W'(terms.green);
    sum_blue  = base + yuvrgb_pkg::SUM_W'(terms.blue);
    pixel_nxt.red   = yuvrgb_pkg::clamp_channel(sum_red);
    pixel_nxt.green = yuvrgb_pkg::clamp_channel(sum_green);
    pixel_nxt.blue  = yuvrgb_pkg::clamp_channel(sum_blue);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule

### src/yuvrgb_merge.sv
// Merge stage: scale both lanes' channels by 220/256 and pack the output word.
// Depends on yuvrgb_pkg.
`timescale 1ns / 1ps

module yuvrgb_merge (
  input  logic                           clk,
  input  logic                           load,
  input  yuvrgb_pkg::rgb_t               pixel_first,
  input  yuvrgb_pkg::rgb_t               pixel_second,
  output logic [yuvrgb_pkg::OUT_W-1:0]   tdata_r
);

  logic [yuvrgb_pkg::OUT_W-1:0] tdata_nxt;

  assign tdata_nxt = {
    yuvrgb_pkg::scale_channel(pixel_second.blue),
    yuvrgb_pkg::scale_channel(pixel_second.green),
    yuvrgb_pkg::scale_channel(pixel_second.red),
    yuvrgb_pkg::scale_channel(pixel_first.blue),
    yuvrgb_pkg::scale_channel(pixel_first.green),
    yuvrgb_pkg::scale_channel(pixel_first.red)
  };

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= tdata_nxt;
    end
  end

endmodule
